>>> hdl/ics_pkg.sv
// Shared types, constants and the per-command segment table of the ICSP
// command serializer. No dependencies; every other file imports this one.
package ics_pkg;

   localparam int ICS_QUEUE_DEPTH = 2;

   localparam logic [7:0]  OP_LOAD       = 8'h80;
   localparam logic [7:0]  OP_WORD_INC   = 8'h02;
   localparam logic [7:0]  OP_WORD_LAST  = 8'h00;
   localparam logic [7:0]  OP_BYTE       = 8'h00;
   localparam logic [7:0]  OP_ROW_ERASE  = 8'hF0;
   localparam logic [7:0]  OP_BULK_ERASE = 8'h18;
   localparam logic [7:0]  OP_BEGIN      = 8'hE0;
   localparam logic [31:0] ENTRY_KEY     = 32'h4D43_4850;

   localparam logic [7:0] DELAY_RESET = 8'd2;
   localparam logic [7:0] LEAD_RESET  = 8'd1;
   localparam logic [7:0] HOLD_RESET  = 8'd251;

   localparam logic [1:0] CSR_DELAY = 2'd0;
   localparam logic [1:0] CSR_LEAD  = 2'd1;
   localparam logic [1:0] CSR_HOLD  = 2'd2;

   typedef enum logic [2:0] {
      ACT_LOAD_ADDR  = 3'd0,
      ACT_WRITE_WORD = 3'd1,
      ACT_WRITE_BYTE = 3'd2,
      ACT_ROW_ERASE  = 3'd3,
      ACT_BULK_ERASE = 3'd4,
      ACT_BEGIN_PROG = 3'd5,
      ACT_ENTER      = 3'd6,
      ACT_EXIT       = 3'd7
   } action_type;

   typedef enum logic [1:0] {SEG_BITS, SEG_IDLE, SEG_END} seg_kind_type;
   typedef enum logic [1:0] {SRC_OPCODE, SRC_PAYLOAD, SRC_ERASE} bit_src_type;
   typedef enum logic [1:0] {LEN_DELAY, LEN_ONE, LEN_LEAD, LEN_HOLD} len_src_type;

   typedef struct packed {
      logic [2:0]  action;
      logic [15:0] address;
      logic [7:0]  data_high;
      logic [7:0]  data_low;
      logic        last_word;
   } req_type;

   typedef struct packed {
      logic       data_bit;
      logic       clock_pulse;
      logic [7:0] idle_count;
      logic       reset_low;
      logic       last_slot;
   } rsp_type;

   typedef struct packed {
      logic [7:0] delay_slots;
      logic [7:0] entry_lead_slots;
      logic [7:0] entry_hold_slots;
   } cfg_type;

   // classified command as it sits in the queue
   typedef struct packed {
      action_type  action;
      logic [7:0]  opcode;
      logic [31:0] payload;
   } cmd_type;

   typedef struct packed {
      seg_kind_type kind;
      bit_src_type  bit_src;
      logic [5:0]   nbits;
      len_src_type  len_src;
      logic         set_mode;
      logic         clr_mode;
      logic         tail;      // final idle run of the command
      logic         pre_tail;  // bits followed only by an idle of delay_slots
   } seg_type;

   function automatic seg_type seg_bits(bit_src_type src, logic [5:0] n, logic pre);
      seg_type s;
      s          = '0;
      s.kind     = SEG_BITS;
      s.bit_src  = src;
      s.nbits    = n;
      s.pre_tail = pre;
      return s;
   endfunction

   function automatic seg_type seg_idle(len_src_type src, logic last, logic setm);
      seg_type s;
      s          = '0;
      s.kind     = SEG_IDLE;
      s.len_src  = src;
      s.tail     = last;
      s.set_mode = setm;
      return s;
   endfunction

   // segment list of each command, indexed by step
   function automatic seg_type seg_of(action_type action, logic [2:0] step);
      seg_type s;
      s      = '0;
      s.kind = SEG_END;
      case (action)
         ACT_LOAD_ADDR, ACT_WRITE_WORD, ACT_WRITE_BYTE: begin
            case (step)
               3'd0:    s = seg_bits(SRC_OPCODE, 6'd8, 1'b0);
               3'd1:    s = seg_idle(LEN_DELAY, 1'b0, 1'b0);
               3'd2:    s = seg_bits(SRC_PAYLOAD, 6'd24, 1'b1);
               3'd3:    s = seg_idle(LEN_DELAY, 1'b1, 1'b0);
               default: s.kind = SEG_END;
            endcase
         end
         ACT_ROW_ERASE: begin
            case (step)
               3'd0:    s = seg_bits(SRC_OPCODE, 6'd8, 1'b0);
               3'd1:    s = seg_idle(LEN_DELAY, 1'b0, 1'b0);
               3'd2:    s = seg_bits(SRC_PAYLOAD, 6'd24, 1'b0);
               3'd3:    s = seg_idle(LEN_DELAY, 1'b0, 1'b0);
               3'd4:    s = seg_bits(SRC_ERASE, 6'd8, 1'b0);
               3'd5:    s = seg_idle(LEN_ONE, 1'b1, 1'b0);
               default: s.kind = SEG_END;
            endcase
         end
         ACT_BULK_ERASE, ACT_BEGIN_PROG: begin
            case (step)
               3'd0:    s = seg_bits(SRC_OPCODE, 6'd8, 1'b0);
               3'd1:    s = seg_idle(LEN_ONE, 1'b1, 1'b0);
               default: s.kind = SEG_END;
            endcase
         end
         ACT_ENTER: begin
            case (step)
               3'd0:    s = seg_idle(LEN_LEAD, 1'b0, 1'b0);
               3'd1:    s = seg_idle(LEN_HOLD, 1'b0, 1'b1);
               3'd2:    s = seg_bits(SRC_PAYLOAD, 6'd32, 1'b1);
               3'd3:    s = seg_idle(LEN_DELAY, 1'b1, 1'b0);
               default: s.kind = SEG_END;
            endcase
         end
         default: s.clr_mode = 1'b1;
      endcase
      return s;
   endfunction

endpackage

>>> hdl/ics_front.sv
// Front end: takes request beats and turns them into queue entries
// (opcode plus payload word). Depends on ics_pkg.
module ics_front import ics_pkg::*; (
   input  logic    req_valid,
   input  req_type req_data,
   output logic    req_stall,
   input  logic    q_full,
   output logic    push,
   output cmd_type push_entry
);

   action_type act;

   assign act       = action_type'(req_data.action);
   assign req_stall = q_full;
   assign push      = req_valid & ~q_full;

   always_comb begin
      push_entry.action  = act;
      push_entry.opcode  = '0;
      push_entry.payload = '0;
      case (act)
         ACT_LOAD_ADDR, ACT_ROW_ERASE: begin
            push_entry.opcode  = OP_LOAD;
            push_entry.payload = {15'd0, req_data.address, 1'b0};
         end
         ACT_WRITE_WORD: begin
            push_entry.opcode  = req_data.last_word ? OP_WORD_LAST : OP_WORD_INC;
            push_entry.payload = {15'd0, req_data.data_high, req_data.data_low, 1'b0};
         end
         ACT_WRITE_BYTE: begin
            push_entry.opcode  = OP_BYTE;
            push_entry.payload = {23'd0, req_data.data_low, 1'b0};
         end
         ACT_BULK_ERASE: push_entry.opcode  = OP_BULK_ERASE;
         ACT_BEGIN_PROG: push_entry.opcode  = OP_BEGIN;
         ACT_ENTER:      push_entry.payload = ENTRY_KEY;
         default:        push_entry.opcode  = '0;
      endcase
   end

endmodule

>>> hdl/ics_queue.sv
// Short command queue between the front end and the slot sequencer.
// Depends on ics_pkg.
module ics_queue import ics_pkg::*; #(
   parameter int DEPTH = ICS_QUEUE_DEPTH
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_entry,
   input  logic    pop,
   output cmd_type head,
   output logic    not_empty,
   output logic    full
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   cmd_type         mem_ff [DEPTH];
   logic [PW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]   count_ff, count_in;

   assign head      = mem_ff[rd_ptr_ff];
   assign not_empty = (count_ff != '0);
   assign full      = (count_ff == CW'(DEPTH));

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push)
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      if (pop)
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      count_in = count_ff + CW'(push) - CW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push)
         mem_ff[wr_ptr_ff] <= push_entry;
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      full |-> !(push && !pop))
      else $error("queue written while full");

endmodule

>>> hdl/ics_back.sv
// Back end: walks each command's segment list, one slot per cycle while not
// stalled, into rsp_data; holds program-mode state. Depends on ics_pkg.
module ics_back import ics_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    q_not_empty,
   input  cmd_type q_head,
   output logic    q_pop,
   input  cfg_type cfg,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   logic        busy_ff, busy_in;
   cmd_type     entry_ff, entry_in;
   logic [2:0]  step_ff, step_in;
   logic [4:0]  pos_ff, pos_in;
   logic        mode_ff, mode_in;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_data_ff, rsp_data_in;

   seg_type     seg;
   logic        can_out;
   logic        emit;
   rsp_type     slot;
   logic [7:0]  idle_len;
   logic [31:0] word;
   logic [5:0]  bit_index;
   logic        bit_last;

   assign seg       = seg_of(entry_ff.action, step_ff);
   assign can_out   = ~rsp_valid_ff | ~rsp_stall;
   assign bit_index = seg.nbits - 6'd1 - {1'b0, pos_ff};
   assign bit_last  = ({1'b0, pos_ff} == seg.nbits - 6'd1);

   always_comb begin
      case (seg.len_src)
         LEN_DELAY: idle_len = cfg.delay_slots;
         LEN_ONE:   idle_len = 8'd1;
         LEN_LEAD:  idle_len = cfg.entry_lead_slots;
         LEN_HOLD:  idle_len = cfg.entry_hold_slots;
         default:   idle_len = 8'd1;
      endcase
      case (seg.bit_src)
         SRC_OPCODE:  word = {24'd0, entry_ff.opcode};
         SRC_PAYLOAD: word = entry_ff.payload;
         SRC_ERASE:   word = {24'd0, OP_ROW_ERASE};
         default:     word = '0;
      endcase
   end

   always_comb begin
      busy_in  = busy_ff;
      entry_in = entry_ff;
      step_in  = step_ff;
      pos_in   = pos_ff;
      mode_in  = mode_ff;
      emit     = 1'b0;
      slot     = '0;
      q_pop    = 1'b0;
      if (busy_ff) begin
         case (seg.kind)
            SEG_BITS: begin
               if (can_out) begin
                  emit             = 1'b1;
                  slot.data_bit    = word[bit_index[4:0]];
                  slot.clock_pulse = 1'b1;
                  slot.reset_low   = mode_ff;
                  slot.last_slot   = seg.pre_tail & bit_last &
                                     (cfg.delay_slots == 8'd0);
                  if (bit_last) begin
                     step_in = step_ff + 3'd1;
                     pos_in  = '0;
                  end else begin
                     pos_in  = pos_ff + 5'd1;
                  end
               end
            end
            SEG_IDLE: begin
               if (can_out) begin
                  emit            = (idle_len != 8'd0);
                  slot.idle_count = idle_len;
                  slot.reset_low  = mode_ff | seg.set_mode;
                  slot.last_slot  = seg.tail;
                  if (seg.set_mode)
                     mode_in = 1'b1;
                  step_in = step_ff + 3'd1;
                  pos_in  = '0;
               end
            end
            SEG_END: begin
               if (seg.clr_mode)
                  mode_in = 1'b0;
               busy_in = 1'b0;
            end
            default: busy_in = 1'b0;
         endcase
      end
      if (q_not_empty && (!busy_ff || seg.kind == SEG_END)) begin
         q_pop    = 1'b1;
         busy_in  = 1'b1;
         entry_in = q_head;
         step_in  = '0;
         pos_in   = '0;
      end
      rsp_valid_in = emit | (rsp_valid_ff & rsp_stall);
      rsp_data_in  = emit ? slot : rsp_data_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         step_ff      <= '0;
         pos_ff       <= '0;
         mode_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         step_ff      <= step_in;
         pos_ff       <= pos_in;
         mode_ff      <= mode_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff    <= entry_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_bit_slot_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.clock_pulse |-> rsp_data_ff.idle_count == 8'd0)
      else $error("bit slot carries an idle count");

   a_idle_slot_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_data_ff.clock_pulse |->
         rsp_data_ff.idle_count != 8'd0 && !rsp_data_ff.data_bit)
      else $error("idle slot malformed");

   a_pos_in_range: assert property (@(posedge clock) disable iff (reset)
      busy_ff && seg.kind == SEG_BITS |-> {1'b0, pos_ff} < seg.nbits)
      else $error("bit position past segment length");

endmodule

>>> hdl/icsp_command_serializer_unit.sv
// Top level of the ICSP command serializer: configuration registers and
// the front end / queue / back end chain. Depends on ics_pkg, ics_front,
// ics_queue and ics_back.
//
// req_*  : one command per beat, taken when req_valid is high and req_stall
//          low; req_stall rises only while the QUEUE_DEPTH-entry queue is full.
// rsp_*  : one waveform slot per beat, a clocked data bit (MSB first) or an
//          idle run of idle_count slots; last_slot marks the final slot of a
//          command. Exit-program-mode emits no slot.
// csr_*  : register writes (0 delay_slots, 1 entry_lead_slots, 2 entry_hold_slots);
//          csr_ready is always high, other indexes are dropped. Write only
//          while no command is in flight.
// A command's first slot passes the queue, the sequencer's entry register and
// the response register in turn. Throughput: one slot per cycle while rsp is
// not stalled; the sequencer ends one command before it takes the next.
// Reset (synchronous, active high) empties the queue, ends program mode
// (reset_low 0) and loads the registers with 2, 1 and 251.
// A stalled rsp beat holds; the sequencer pauses and the queue keeps taking
// commands until it fills.
module icsp_command_serializer_unit import ics_pkg::*; #(
   parameter int QUEUE_DEPTH = ICS_QUEUE_DEPTH
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  req_type    req_data,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output rsp_type    rsp_data,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [1:0] csr_index,
   input  logic [7:0] csr_data
);

   cfg_type cfg_ff, cfg_in;
   logic    q_full;
   logic    q_not_empty;
   logic    push;
   logic    pop;
   cmd_type push_entry;
   cmd_type q_head;

   // registers can always take a write
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_DELAY: cfg_in.delay_slots      = csr_data;
            CSR_LEAD:  cfg_in.entry_lead_slots = csr_data;
            CSR_HOLD:  cfg_in.entry_hold_slots = csr_data;
            default:   cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.delay_slots      <= DELAY_RESET;
         cfg_ff.entry_lead_slots <= LEAD_RESET;
         cfg_ff.entry_hold_slots <= HOLD_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // classify the command into opcode and payload word
   ics_front u_front (
      .req_valid  (req_valid),
      .req_data   (req_data),
      .req_stall  (req_stall),
      .q_full     (q_full),
      .push       (push),
      .push_entry (push_entry)
   );

   // decouples command intake from slot generation
   ics_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (q_head),
      .not_empty  (q_not_empty),
      .full       (q_full)
   );

   // slot sequencer with the output register
   ics_back u_back (
      .clock       (clock),
      .reset       (reset),
      .q_not_empty (q_not_empty),
      .q_head      (q_head),
      .q_pop       (pop),
      .cfg         (cfg_ff),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data)
   );

endmodule
